// File: sv/length_prefixed_frame_reassembler_unit_macros.svh
// assertion helpers shared by the reassembler modules
`ifndef LENGTH_PREFIXED_FRAME_REASSEMBLER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_REASSEMBLER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define LPFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LPFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lpfr_pkg.sv
package lpfr_pkg;

  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 13;
  localparam int CNT_W        = 13;
  localparam int HEADER_BYTES = 8;
  localparam int MAX_MESSAGE  = 4096;
  localparam int CFG_IDX_W    = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'b1;

  // reset values of the configuration registers
  localparam logic [LEN_W-1:0] MIN_LENGTH_RST = LEN_W'(HEADER_BYTES);
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(MAX_MESSAGE);

  typedef enum logic [2:0] {
    S_COLLECT,
    S_CHECK,
    S_ERR,
    S_HDR,
    S_PASS
  } state_t;

  typedef enum logic [1:0] {
    OUT_ERR,
    OUT_HDR,
    OUT_PASS
  } out_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     hdr_shift_in;
    logic     hdr_rotate;
    logic     count_clr;
    logic     count_inc;
    logic     len_latch;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_hdr_last;
    logic len_ok;
    logic len_is_hdr;
    logic pass_last;
    logic out_free;
  } status_t;

endpackage

// File: sv/lpfr_ctrl.sv
`include "length_prefixed_frame_reassembler_unit_macros.svh"

module lpfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  lpfr_pkg::status_t sts,
  output lpfr_pkg::cmd_t   cmd,
  output logic             in_stall
);
  import lpfr_pkg::*;

  state_t state;
  state_t state_next;
  logic   in_fire;

  assign in_fire = in_valid && !in_stall;

  // input side is open while collecting, and while passing if the output can take the item
  always_comb begin
    unique case (state)
      S_COLLECT: in_stall = 1'b0;
      S_PASS:    in_stall = !sts.out_free;
      default:   in_stall = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_COLLECT: begin
        if (in_fire && sts.count_hdr_last) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = sts.len_ok ? S_HDR : S_ERR;
      end
      S_ERR: begin
        if (sts.out_free) state_next = S_COLLECT;
      end
      S_HDR: begin
        if (sts.out_free && sts.count_hdr_last) begin
          state_next = sts.len_is_hdr ? S_COLLECT : S_PASS;
        end
      end
      S_PASS: begin
        if (in_fire && sts.pass_last) state_next = S_COLLECT;
      end
      default: state_next = S_COLLECT;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    cmd.out_sel = OUT_PASS;
    unique case (state)
      S_COLLECT: begin
        cmd.hdr_shift_in = in_fire;
        cmd.count_inc    = in_fire;
      end
      S_CHECK: begin
        cmd.len_latch = sts.len_ok;
        cmd.count_clr = 1'b1;
      end
      S_ERR: begin
        cmd.out_load  = sts.out_free;
        cmd.out_sel   = OUT_ERR;
      end
      S_HDR: begin
        cmd.out_load   = sts.out_free;
        cmd.out_sel    = OUT_HDR;
        cmd.hdr_rotate = sts.out_free;
        // header-only message restarts the count, otherwise count on into the body
        cmd.count_clr  = sts.out_free && sts.count_hdr_last && sts.len_is_hdr;
        cmd.count_inc  = sts.out_free && !(sts.count_hdr_last && sts.len_is_hdr);
      end
      S_PASS: begin
        cmd.out_load  = in_fire;
        cmd.out_sel   = OUT_PASS;
        cmd.count_clr = in_fire && sts.pass_last;
        cmd.count_inc = in_fire && !sts.pass_last;
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  `LPFR_ASSERT_NEXT(a_eighth_byte_checks, in_fire && state == S_COLLECT && sts.count_hdr_last,
                    state == S_CHECK, "eighth header byte did not lead to the length check")
  `LPFR_ASSERT_NEXT(a_err_resyncs, state == S_ERR && sts.out_free,
                    state == S_COLLECT, "error item did not restart header collection")

endmodule

// File: sv/lpfr_dp.sv
`include "length_prefixed_frame_reassembler_unit_macros.svh"

module lpfr_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [lpfr_pkg::BYTE_W-1:0]         in_byte,
  input  logic                                cfg_we,
  input  logic [lpfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpfr_pkg::LEN_W-1:0]          cfg_data,
  input  lpfr_pkg::cmd_t                      cmd,
  output lpfr_pkg::status_t                   sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lpfr_pkg::BYTE_W-1:0]         out_byte,
  output logic [lpfr_pkg::LEN_W-1:0]          msg_length,
  output logic                                last,
  output logic                                length_error
);
  import lpfr_pkg::*;

  logic [BYTE_W-1:0] hdr [HEADER_BYTES];
  logic [CNT_W-1:0]  count;
  logic [CNT_W:0]    count_plus;
  logic [LEN_W-1:0]  expected;
  logic [LEN_W-1:0]  min_length;
  logic [LEN_W-1:0]  max_length;
  logic [LEN_W-1:0]  lo_bound;
  logic [LEN_W-1:0]  hi_bound;
  logic [31:0]       hdr_len;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RST;
      max_length <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_LENGTH: min_length <= cfg_data;
        CFG_MAX_LENGTH: max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // header shift line: new bytes enter at the tail, emit rotates the head out
  always_ff @(posedge clk) begin
    if (cmd.hdr_shift_in) begin
      for (int i = 0; i < HEADER_BYTES - 1; i++) hdr[i] <= hdr[i+1];
      hdr[HEADER_BYTES-1] <= in_byte;
    end else if (cmd.hdr_rotate) begin
      for (int i = 0; i < HEADER_BYTES - 1; i++) hdr[i] <= hdr[i+1];
      hdr[HEADER_BYTES-1] <= hdr[0];
    end
  end

  // byte counter and latched message length
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      expected <= '0;
    end else begin
      if (cmd.count_clr) begin
        count <= '0;
      end else if (cmd.count_inc) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.len_latch) expected <= hdr_len[LEN_W-1:0];
    end
  end

  // length check against clamped bounds
  assign hdr_len  = {hdr[4], hdr[5], hdr[6], hdr[7]};
  assign lo_bound = (min_length < LEN_W'(HEADER_BYTES)) ? LEN_W'(HEADER_BYTES) : min_length;
  assign hi_bound = (max_length > LEN_W'(MAX_MESSAGE)) ? LEN_W'(MAX_MESSAGE) : max_length;
  assign count_plus = {1'b0, count} + (CNT_W+1)'(1);

  assign sts.len_ok = (hdr_len[31:LEN_W] == '0) &&
                      (hdr_len[LEN_W-1:0] >= lo_bound) &&
                      (hdr_len[LEN_W-1:0] <= hi_bound);
  assign sts.count_hdr_last = (count == CNT_W'(HEADER_BYTES - 1));
  assign sts.len_is_hdr     = (expected == LEN_W'(HEADER_BYTES));
  assign sts.pass_last      = (count_plus >= {1'b0, expected});
  assign sts.out_free       = !out_valid || !out_stall;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        OUT_ERR: begin
          out_byte     <= '0;
          msg_length   <= '0;
          last         <= 1'b0;
          length_error <= 1'b1;
        end
        OUT_HDR: begin
          out_byte     <= hdr[0];
          msg_length   <= expected;
          last         <= sts.count_hdr_last && sts.len_is_hdr;
          length_error <= 1'b0;
        end
        OUT_PASS: begin
          out_byte     <= in_byte;
          msg_length   <= expected;
          last         <= sts.pass_last;
          length_error <= 1'b0;
        end
        default: begin
          out_byte     <= '0;
          msg_length   <= '0;
          last         <= 1'b0;
          length_error <= 1'b1;
        end
      endcase
    end
  end

  `LPFR_ASSERT_NOW(a_err_item_clean, out_valid && length_error,
                   out_byte == '0 && msg_length == '0 && !last,
                   "error item carries message fields")
  `LPFR_ASSERT_NOW(a_msg_item_has_length, out_valid && !length_error,
                   msg_length >= LEN_W'(HEADER_BYTES),
                   "message item with length below header size")

endmodule

// File: sv/length_prefixed_frame_reassembler_unit.sv
// Length-prefixed frame reassembler. One byte enters per accepted input item.
// The first eight bytes of a message are collected in a shift line; bytes 4..7
// hold a big-endian total length (header included) that is checked against
// min_length (at least 8) and max_length (at most 4096) in a check state.
// A good header is then sent out as eight items, one per cycle while the
// output is not stalled, followed by each body byte as it arrives, every
// item tagged with msg_length and the final one with last. A bad length
// gives a single item with length_error set and collection restarts at the
// next byte. Header bytes are taken one per cycle; input is held off during
// the check and the header burst; body bytes pass at one per cycle while the
// output is not stalled. The single output register sets the body rate.
// Register writes (index 0 min_length, 1 max_length) apply at the next
// header check.
module length_prefixed_frame_reassembler_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lpfr_pkg::BYTE_W-1:0]        in_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lpfr_pkg::BYTE_W-1:0]        out_byte,
  output logic [lpfr_pkg::LEN_W-1:0]         msg_length,
  output logic                               last,
  output logic                               length_error,
  input  logic                               cfg_we,
  input  logic [lpfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpfr_pkg::LEN_W-1:0]         cfg_data
);
  import lpfr_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // sequencer
  lpfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // header store, counters, length check, output register
  lpfr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_byte      (in_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .msg_length   (msg_length),
    .last         (last),
    .length_error (length_error)
  );

endmodule
